FILE: hw/rtl/nam_pkg.sv
package nam_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int ETA_W    = 13;
   localparam int PHI_W    = 12;
   localparam int KEY_W    = 16;
   localparam int RADIUS_W = 12;
   localparam int DETA_W   = ETA_W + 1;           // exact eta difference
   localparam int AETA_W   = ETA_W;               // |deta| <= 8191
   localparam int SQE_W    = 2 * AETA_W;          // deta squared
   localparam int SQP_W    = 2 * PHI_W;           // dphi squared
   localparam int DIST_W   = SQE_W + 1;           // sum of both squares
   localparam int R2_W     = 2 * RADIUS_W;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(205);

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   typedef enum logic [2:0] {
      STAT_CLEARED = 3'd0,
      STAT_LOADED  = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_MATCHED = 3'd3,
      STAT_NOMATCH = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [ETA_W-1:0] eta;
      logic signed [PHI_W-1:0] phi;
      logic [KEY_W-1:0]        key;
   } cand_type;

endpackage

FILE: hw/rtl/nam_table.sv
module nam_table (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [nam_pkg::IDX_W-1:0]  wr_addr,
   input  nam_pkg::cand_type          wr_data,
   input  logic                       rd_en,
   input  logic [nam_pkg::IDX_W-1:0]  rd_addr,
   output nam_pkg::cand_type          rd_data
);
   import nam_pkg::*;

   // candidate storage, one write and one registered read port
   cand_type mem [MAX_ENTRIES];
   cand_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/nearest_angular_match_within_radius.sv
// Clear, load, spare code and a query on an empty table go from idle straight to the done
// state; the result register loads from there once the output register is free, and the
// block then returns to idle to take the next transaction. Query: one candidate read per
// cycle from the single memory read port, then two compare stages and the drain state;
// the result register then loads from the done state in the same way.
// Reset (synchronous, active high) empties the table and sets the radius to 205.
module nearest_angular_match_within_radius (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic signed [nam_pkg::ETA_W-1:0] req_eta,
   input  logic signed [nam_pkg::PHI_W-1:0] req_phi,
   input  logic [nam_pkg::KEY_W-1:0]     req_entry_key,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [nam_pkg::KEY_W-1:0]     rsp_matched_key,
   // radius register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [nam_pkg::RADIUS_W-1:0]  csr_data
);
   import nam_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   // ------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_fire;
   logic             out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid & ~req_stall;
   // output register can take a new result this cycle
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign csr_ready = 1'b1;

   // ------------------------------------------------------------------
   // radius register and its square
   // ------------------------------------------------------------------
   logic [RADIUS_W-1:0] radius_ff;
   logic [R2_W-1:0]     r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_data;
      end
   end

   // square once per query; held for the whole scan
   always_ff @(posedge clock) begin
      if (req_fire && req_type == REQ_QUERY) begin
         r2_ff <= radius_ff * radius_ff;
      end
   end

   // ------------------------------------------------------------------
   // table fill count
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] count_ff;
   logic             table_full;

   assign table_full = (count_ff == CNT_W'(MAX_ENTRIES));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_fire) begin
         case (req_type)
            REQ_CLEAR: count_ff <= '0;
            REQ_LOAD: begin
               if (!table_full) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            default: count_ff <= count_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // candidate memory
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             wr_en;
   cand_type         wr_data;
   logic             rd_en;
   cand_type         rd_data;

   assign wr_en       = req_fire && (req_type == REQ_LOAD) && !table_full;
   assign wr_data.eta = req_eta;
   assign wr_data.phi = req_phi;
   assign wr_data.key = req_entry_key;
   assign rd_en       = (state_ff == S_SCAN);

   nam_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------
   // query point
   // ------------------------------------------------------------------
   logic signed [ETA_W-1:0] q_eta_ff;
   logic signed [PHI_W-1:0] q_phi_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         q_eta_ff <= req_eta;
         q_phi_ff <= req_phi;
      end
   end

   // ------------------------------------------------------------------
   // distance pipeline: read data -> squares -> sum and compare
   // ------------------------------------------------------------------
   logic                     rd_vld_ff;
   logic                     sq_vld_ff;
   logic signed [DETA_W-1:0] deta;
   logic signed [PHI_W-1:0]  dphi;
   logic [AETA_W-1:0]        aeta;
   logic [PHI_W-1:0]         aphi;
   logic [SQE_W-1:0]         sq_e_ff, sq_e_in;
   logic [SQP_W-1:0]         sq_p_ff, sq_p_in;
   logic [KEY_W-1:0]         sq_key_ff;

   always_comb begin
      deta    = DETA_W'(q_eta_ff) - DETA_W'(rd_data.eta);
      // phi difference wraps to 12 bits by truncation
      dphi    = q_phi_ff - rd_data.phi;
      aeta    = deta[DETA_W-1] ? AETA_W'(-deta) : AETA_W'(deta);
      aphi    = dphi[PHI_W-1] ? PHI_W'(-dphi) : PHI_W'(dphi);
      sq_e_in = aeta * aeta;
      sq_p_in = aphi * aphi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         sq_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         sq_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         sq_e_ff   <= sq_e_in;
         sq_p_ff   <= sq_p_in;
         sq_key_ff <= rd_data.key;
      end
   end

   // best-so-far; a later entry wins only when strictly nearer
   logic [DIST_W-1:0] dist_sq;
   logic              take;
   logic              found_ff;
   logic [DIST_W-1:0] best_ff;
   logic [KEY_W-1:0]  best_key_ff;

   assign dist_sq = DIST_W'(sq_e_ff) + DIST_W'(sq_p_ff);
   assign take    = sq_vld_ff && (dist_sq < DIST_W'(r2_ff)) &&
                    (!found_ff || dist_sq < best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (req_fire) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_ff     <= dist_sq;
         best_key_ff <= sq_key_ff;
      end
   end

   // ------------------------------------------------------------------
   // sequencer and result registers
   // ------------------------------------------------------------------
   status_type       pend_status_ff, pend_status_in;
   logic [KEY_W-1:0] pend_key_ff, pend_key_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic             scan_last;

   assign scan_last = (scan_idx_ff == count_ff - CNT_W'(1));

   always_comb begin
      state_in       = state_ff;
      scan_idx_in    = scan_idx_ff;
      pend_status_in = pend_status_ff;
      pend_key_in    = pend_key_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_key_in     = rsp_key_ff;

      // drop the output once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pend_key_in = '0;
               state_in    = S_DONE;
               case (req_type)
                  REQ_CLEAR: pend_status_in = STAT_CLEARED;
                  REQ_LOAD:  pend_status_in = table_full ? STAT_FULL : STAT_LOADED;
                  REQ_QUERY: begin
                     pend_status_in = STAT_NOMATCH;
                     // empty table answers no match at once
                     if (count_ff != '0) begin
                        scan_idx_in = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  default:   pend_status_in = STAT_NOMATCH;
               endcase
            end
         end
         S_SCAN: begin
            // advance one entry per cycle
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            if (scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // hold until the last compare has retired
            if (!rd_vld_ff && !sq_vld_ff) begin
               if (found_ff) begin
                  pend_status_in = STAT_MATCHED;
                  pend_key_in    = best_key_ff;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_key_in    = pend_key_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff    <= scan_idx_in;
      pend_status_ff <= pend_status_in;
      pend_key_ff    <= pend_key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_key_ff     <= rsp_key_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_matched_key = rsp_key_ff;

endmodule

FILE: verif/nearest_angular_match_within_radius_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the nearest angular match block.
// Keep a shadow copy of the candidate table and the radius, predict every
// response at the moment its request transaction is accepted, and compare
// each response transaction with the oldest prediction.
module nearest_angular_match_within_radius_tb;
   import nam_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;       // spare request code, answers no match
   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int MAX_GAP       = 15;              // longest random idle per transaction
   localparam int REPORT_LIMIT  = 10;              // faults shown in full
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = MAX_ENTRIES + 16; // a full-table scan plus pipeline
   localparam int HOLD_CYCLES   = 400;

   typedef struct {
      status_type       status;
      logic [KEY_W-1:0] key;
   } reply_rec;

   // Drive every input to a known value from time zero.
   logic                       clock;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_type      = REQ_CLEAR;
   logic signed [ETA_W-1:0]    req_eta       = '0;
   logic signed [PHI_W-1:0]    req_phi       = '0;
   logic [KEY_W-1:0]           req_entry_key = '0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic [2:0]                 rsp_status;
   logic [KEY_W-1:0]           rsp_matched_key;
   logic                       csr_valid     = 1'b0;
   logic                       csr_ready;
   logic [RADIUS_W-1:0]        csr_data      = '0;

   // Shadow of the candidate table and the radius register.
   logic signed [ETA_W-1:0]    shadow_eta [MAX_ENTRIES];
   logic signed [PHI_W-1:0]    shadow_phi [MAX_ENTRIES];
   logic [KEY_W-1:0]           shadow_key [MAX_ENTRIES];
   int                         shadow_count = 0;
   logic [RADIUS_W-1:0]        radius_now   = RADIUS_RESET;

   reply_rec                   replies_due [$];
   int                         fault_count  = 0;
   int                         reply_count  = 0;
   int                         n_clear = 0, n_load = 0, n_full = 0;
   int                         n_query = 0, n_matched = 0, n_unused = 0, n_radius = 0;

   // Idle controls shared between the test sequence and the response side.
   bit                         tx_idle_on     = 1'b1;
   bit                         rx_idle_on     = 1'b1;
   int                         rx_hold_cycles = 0;

   nearest_angular_match_within_radius u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_eta         (req_eta),
      .req_phi         (req_phi),
      .req_entry_key   (req_entry_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_matched_key (rsp_matched_key),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Stop a hung run; the slowest legal run is far below this.
   initial begin
      #(CLOCK_PERIOD * 1000000);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void report_fault(input string msg);
      if (fault_count < REPORT_LIMIT) begin
         $display("%0t: %s", $time, msg);
      end
      fault_count++;
   endfunction

   // Apply one request to the shadow table and return the response it must cause.
   function automatic reply_rec table_response(input logic [1:0] kind,
                                               input logic signed [ETA_W-1:0] eta,
                                               input logic signed [PHI_W-1:0] phi,
                                               input logic [KEY_W-1:0] key);
      reply_rec         r;
      longint           limit2;
      longint           d2;
      longint           best;
      int               de;
      int               dp;
      logic [PHI_W-1:0] dphi_wrapped;
      bit               found;
      r.status = STAT_NOMATCH;
      r.key    = '0;
      case (kind)
         REQ_CLEAR: begin
            shadow_count = 0;
            r.status = STAT_CLEARED;
            n_clear++;
         end
         REQ_LOAD: begin
            if (shadow_count < MAX_ENTRIES) begin
               shadow_eta[shadow_count] = eta;
               shadow_phi[shadow_count] = phi;
               shadow_key[shadow_count] = key;
               shadow_count++;
               r.status = STAT_LOADED;
               n_load++;
            end else begin
               // drop the entry, table unchanged
               r.status = STAT_FULL;
               n_full++;
            end
         end
         REQ_QUERY: begin
            n_query++;
            limit2 = longint'(radius_now) * longint'(radius_now);
            found  = 1'b0;
            best   = 0;
            // Scan in load order; replace only on strictly nearer, so the
            // earliest entry wins a tie.
            for (int i = 0; i < shadow_count; i++) begin
               de           = int'(eta) - int'(shadow_eta[i]);
               dphi_wrapped = phi - shadow_phi[i];          // wrap to 12 bits
               dp           = int'($signed(dphi_wrapped));
               d2           = longint'(de) * de + longint'(dp) * dp;
               if (d2 < limit2 && (!found || d2 < best)) begin
                  best  = d2;
                  found = 1'b1;
                  r.key = shadow_key[i];
               end
            end
            if (found) begin
               r.status = STAT_MATCHED;
               n_matched++;
            end
         end
         default: n_unused++;
      endcase
      return r;
   endfunction

   // Offer one request transaction and hold it until accepted. Leave valid
   // high afterwards; the next call either replaces the payload or drops it.
   task automatic send_request(input logic [1:0] kind,
                               input logic signed [ETA_W-1:0] eta,
                               input logic signed [PHI_W-1:0] phi,
                               input logic [KEY_W-1:0] key);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_eta       <= eta;
      req_phi       <= phi;
      req_entry_key <= key;
      do @(posedge clock); while (req_stall !== 1'b0);
      replies_due.insert(replies_due.size(), table_response(kind, eta, phi, key));
   endtask

   // Drop valid and wait until every predicted response has been seen.
   task automatic await_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_due.size() != 0);
   endtask

   // Write the radius only with the block idle, then track it in the shadow.
   task automatic write_radius(input logic [RADIUS_W-1:0] value);
      await_replies();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      radius_now = value;
      n_radius++;
   endtask

   // Query a point scattered around a stored entry; eta saturates, phi wraps.
   task automatic query_near(input int idx, input int span);
      int                      off;
      int                      e;
      logic signed [PHI_W-1:0] p;
      off = $urandom_range(0, 2 * span);
      e   = int'(shadow_eta[idx]) + off - span;
      if (e > 4095) e = 4095;
      if (e < -4096) e = -4096;
      off = $urandom_range(0, 2 * span);
      p   = shadow_phi[idx] + PHI_W'(off - span);
      send_request(REQ_QUERY, ETA_W'(e), p, KEY_W'($urandom));
   endtask

   // Bursts (mostly opening with a clear, then loads and queries) with random content, salted
   // with stray requests of any code. Mostly short tables, now and then a
   // table that overflows.
   task automatic run_table_bursts(input int target);
      int start;
      int loads;
      int pick;
      int span;
      start = n_clear + n_load + n_full + n_query;
      while (n_clear + n_load + n_full + n_query - start < target) begin
         if ($urandom_range(0, 5) != 0) begin
            send_request(REQ_CLEAR, ETA_W'($urandom), PHI_W'($urandom), KEY_W'($urandom));
         end
         loads = ($urandom_range(0, 99) < 6) ? $urandom_range(50, 70) : $urandom_range(0, 12);
         repeat (loads) begin
            if (shadow_count > 0 && $urandom_range(0, 7) == 0) begin
               // repeat a stored point to force distance ties
               pick = $urandom_range(0, shadow_count - 1);
               send_request(REQ_LOAD, shadow_eta[pick], shadow_phi[pick], KEY_W'($urandom));
            end else begin
               send_request(REQ_LOAD, ETA_W'($urandom), PHI_W'($urandom), KEY_W'($urandom));
            end
         end
         span = int'(radius_now) + 3;
         repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 9);
            if (shadow_count > 0 && pick < 7) begin
               query_near($urandom_range(0, shadow_count - 1), span);
            end else if (pick == 9) begin
               send_request(2'($urandom), ETA_W'($urandom), PHI_W'($urandom), KEY_W'($urandom));
            end else begin
               send_request(REQ_QUERY, ETA_W'($urandom), PHI_W'($urandom), KEY_W'($urandom));
            end
         end
      end
   endtask

   // Hand-picked points at the reset radius of 205.
   task automatic test_directed_cases();
      send_request(REQ_QUERY, ETA_W'(0), PHI_W'(0), KEY_W'('hBEEF));       // empty table
      send_request(REQ_UNUSED, ETA_W'(0), PHI_W'(0), KEY_W'('hFFFF));
      send_request(REQ_LOAD, ETA_W'(0), PHI_W'(0), KEY_W'('h0000));
      send_request(REQ_QUERY, ETA_W'(204), PHI_W'(0), KEY_W'('hBEEF));     // just inside
      send_request(REQ_QUERY, ETA_W'(205), PHI_W'(0), KEY_W'('hBEEF));     // on the radius
      send_request(REQ_QUERY, ETA_W'(120), PHI_W'(-165), KEY_W'('hBEEF)); // diagonal, inside
      send_request(REQ_LOAD, ETA_W'(4095), PHI_W'(2047), KEY_W'('hFFFF));
      send_request(REQ_LOAD, ETA_W'(-4096), PHI_W'(-2048), KEY_W'('h1234));
      // phi difference across the wrap point
      send_request(REQ_QUERY, ETA_W'(4095), PHI_W'(-2048), KEY_W'('h0000));
      send_request(REQ_QUERY, ETA_W'(-4096), PHI_W'(2047), KEY_W'('h0000));
      send_request(REQ_QUERY, ETA_W'(-4096), PHI_W'(0), KEY_W'('h0000));  // half a turn
      // equal distances: the earliest entry must win
      send_request(REQ_LOAD, ETA_W'(1000), PHI_W'(10), KEY_W'('hAAAA));
      send_request(REQ_LOAD, ETA_W'(1000), PHI_W'(-10), KEY_W'('h5555));
      send_request(REQ_LOAD, ETA_W'(1000), PHI_W'(10), KEY_W'('h7777));
      send_request(REQ_QUERY, ETA_W'(1000), PHI_W'(0), KEY_W'('h0000));
      send_request(REQ_QUERY, ETA_W'(1000), PHI_W'(-9), KEY_W'('h0000));
      send_request(REQ_CLEAR, ETA_W'(-1), PHI_W'(-1), KEY_W'('hFFFF));
      send_request(REQ_QUERY, ETA_W'(1000), PHI_W'(10), KEY_W'('h0000));
      send_request(REQ_LOAD, ETA_W'(1000), PHI_W'(10), KEY_W'('h0F0F));
      send_request(REQ_QUERY, ETA_W'(1000), PHI_W'(10), KEY_W'('h0000));
   endtask

   // Fill the table, overflow it and scan it at full depth.
   task automatic test_table_full();
      send_request(REQ_CLEAR, ETA_W'($urandom), PHI_W'($urandom), KEY_W'($urandom));
      repeat (MAX_ENTRIES + 2) begin
         send_request(REQ_LOAD, ETA_W'($urandom), PHI_W'($urandom), KEY_W'($urandom));
      end
      query_near(MAX_ENTRIES - 1, int'(radius_now) / 2);
      query_near(0, int'(radius_now) / 2);
      send_request(REQ_QUERY, ETA_W'($urandom), PHI_W'($urandom), KEY_W'($urandom));
   endtask

   // Sweep the radius through both extremes, one, a random value and back to the reset value.
   task automatic test_radius_settings();
      logic [RADIUS_W-1:0] radius_list [5];
      radius_list = '{RADIUS_W'(0), RADIUS_W'(4095), RADIUS_W'(1),
                      RADIUS_W'($urandom_range(2, 4094)), RADIUS_RESET};
      foreach (radius_list[i]) begin
         write_radius(radius_list[i]);
         run_table_bursts(280);
      end
   endtask

   // Hold off the response side for a long stretch while requests keep coming,
   // so the block fills up and stalls its input.
   task automatic test_output_holdoff();
      rx_hold_cycles = HOLD_CYCLES;
      tx_idle_on     = 1'b0;
      run_table_bursts(40);
      tx_idle_on     = 1'b1;
      await_replies();
   endtask

   // Run back to back with no idling on either side, then pause the
   // requests until every response is in, then resume with idling.
   task automatic test_streaming_and_drain();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      run_table_bursts(150);
      await_replies();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      run_table_bursts(30);
   endtask

   // Response side: draw a stall per transaction, or take a requested long
   // hold, then accept one response and check it against the oldest prediction.
   initial begin : reply_checker
      int       hold;
      reply_rec due;
      wait (reset === 1'b0);
      forever begin
         hold           = rx_hold_cycles;
         rx_hold_cycles = 0;
         if (hold == 0 && rx_idle_on) hold = $urandom_range(0, MAX_GAP);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         reply_count++;
         if (replies_due.size() == 0) begin
            report_fault($sformatf("unexpected response: status %0d key %h",
                                   rsp_status, rsp_matched_key));
         end else begin
            due = replies_due.pop_front();
            if (rsp_status !== due.status || rsp_matched_key !== due.key) begin
               report_fault($sformatf("expected status %0d key %h, got status %0d key %h",
                                      due.status, due.key, rsp_status, rsp_matched_key));
            end
         end
      end
   end

   initial begin : test_sequence
      int drained;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_table_full();
      test_radius_settings();
      test_output_holdoff();
      test_streaming_and_drain();

      // Drain: wait for every prediction, then give the block time to show
      // any stray response.
      req_valid <= 1'b0;
      drained = 0;
      do begin
         @(posedge clock);
         drained++;
      end while (replies_due.size() != 0 && drained < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (replies_due.size() != 0) begin
         report_fault($sformatf("%0d predicted responses never arrived", replies_due.size()));
      end

      $display("Run covered %0d clears, %0d loads, %0d drops on a full table, %0d spare codes",
               n_clear, n_load, n_full, n_unused);
      $display("and %0d queries (%0d matched) over %0d radius writes; %0d responses checked",
               n_query, n_matched, n_radius, reply_count);
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: nearest_angular_match_within_radius.f
hw/rtl/nam_pkg.sv
hw/rtl/nam_table.sv
hw/rtl/nearest_angular_match_within_radius.sv
verif/nearest_angular_match_within_radius_tb.sv
